[rtl/arm_forward_kinematics_4dof_unit_macros.svh]
// assertion macros used by the checker file
`ifndef ARM_FORWARD_KINEMATICS_4DOF_UNIT_MACROS_SVH
`define ARM_FORWARD_KINEMATICS_4DOF_UNIT_MACROS_SVH

// overlapping implication, off while reset is high
`define AFK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define AFK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/afk_pkg.sv]
// shared types, constants and functions of the arm kinematics unit
`default_nettype none
package afk_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 12;
  localparam int OUT_BITS     = 20;
  localparam int CORDIC_STEPS = 30;
  localparam int LATENCY      = CORDIC_STEPS + 9;

  typedef logic signed [32:0] ent_t;
  typedef logic signed [35:0] accw_t;

  localparam ent_t GAIN_INV = 33'sd652032874;
  localparam ent_t ONE_Q30  = 33'sd1073741824;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    ent_t       x;
    ent_t       y;
    ent_t       z;
    logic [1:0] q;
  } cord_t;

  typedef struct packed {
    ent_t x;
    ent_t y;
    ent_t z;
  } vec_t;

  typedef struct packed {
    accw_t x;
    accw_t y;
    accw_t z;
  } acc_t;

  typedef struct packed {
    ent_t c;
    ent_t s;
  } trig_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic ent_t atan_val(input logic [4:0] i);
    ent_t r;
    case (i)
      5'd0:  r = 33'sd536870912;
      5'd1:  r = 33'sd316933406;
      5'd2:  r = 33'sd167458907;
      5'd3:  r = 33'sd85004756;
      5'd4:  r = 33'sd42667331;
      5'd5:  r = 33'sd21354465;
      5'd6:  r = 33'sd10679838;
      5'd7:  r = 33'sd5340245;
      5'd8:  r = 33'sd2670163;
      5'd9:  r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;
      5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;
      5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;
      5'd29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/afk_cordic_cell.sv]
// one cordic iteration for the four joint lanes
`default_nettype none
module afk_cordic_cell import afk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  step,
  input  logic        in_valid,
  input  cord_t [3:0] in_lane,
  output logic        out_valid,
  output cord_t [3:0] out_lane
);

  cord_t [3:0] lane_next;

  always_comb begin
    ent_t dx;
    ent_t dy;
    ent_t at;
    at = atan_val(step);
    for (int l = 0; l < 4; l++) begin
      dx = in_lane[l].y >>> step;
      dy = in_lane[l].x >>> step;
      lane_next[l].q = in_lane[l].q;
      if (in_lane[l].z >= 0) begin
        lane_next[l].x = in_lane[l].x - dx;
        lane_next[l].y = in_lane[l].y + dy;
        lane_next[l].z = in_lane[l].z - at;
      end else begin
        lane_next[l].x = in_lane[l].x + dx;
        lane_next[l].y = in_lane[l].y - dy;
        lane_next[l].z = in_lane[l].z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_lane <= lane_next;
  end

endmodule
`default_nettype wire

[rtl/afk_rot_cell.sv]
// plane rotation of two matrix columns, multiply stage then round stage
`default_nettype none
module afk_rot_cell import afk_pkg::*; (
  input  logic clk,
  input  ent_t c,
  input  ent_t s,
  input  vec_t u,
  input  vec_t v,
  output vec_t u_out,
  output vec_t v_out
);

  typedef struct packed {
    logic signed [65:0] x;
    logic signed [65:0] y;
    logic signed [65:0] z;
  } pvec_t;

  pvec_t puc, pvs, pus, pvc;

  // exact sum of two products, rounded half up to q2.30
  function automatic ent_t rnd(input logic signed [65:0] a, input logic signed [65:0] b);
    logic signed [67:0] t;
    t = 68'(a) + 68'(b) + (68'sd1 <<< 29);
    return t[62:30];
  endfunction

  always_ff @(posedge clk) begin
    puc.x <= u.x * c;
    puc.y <= u.y * c;
    puc.z <= u.z * c;
    pvs.x <= v.x * (-s);
    pvs.y <= v.y * (-s);
    pvs.z <= v.z * (-s);
    pus.x <= u.x * s;
    pus.y <= u.y * s;
    pus.z <= u.z * s;
    pvc.x <= v.x * c;
    pvc.y <= v.y * c;
    pvc.z <= v.z * c;
  end

  always_ff @(posedge clk) begin
    u_out.x <= rnd(puc.x, pvs.x);
    u_out.y <= rnd(puc.y, pvs.y);
    u_out.z <= rnd(puc.z, pvs.z);
    v_out.x <= rnd(pus.x, pvc.x);
    v_out.y <= rnd(pus.y, pvc.y);
    v_out.z <= rnd(pus.z, pvc.z);
  end

endmodule
`default_nettype wire

[rtl/arm_forward_kinematics_4dof_unit.sv]
// top level: forward kinematics of a four-joint serial arm
// A start beat is taken in every cycle (busy is always low) and its pos_x, pos_y, pos_z
// appear with done in order; done lasts one cycle and cannot be held off. The pipeline is
// the 30-cell cordic chain (one iteration per cell, all four joints side by side), one
// quadrant/clamp stage, three rotation cells of two stages each (multiply, then round),
// one link-length multiply and one round/saturate stage. The user must write link_length
// through cfg_wr_en/cfg_wr_data only while no beat is in flight; the block does not enforce it.
`default_nettype none
module arm_forward_kinematics_4dof_unit import afk_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [15:0]         joint1_angle,
  input  logic signed [15:0]         joint2_angle,
  input  logic signed [15:0]         joint3_angle,
  input  logic signed [15:0]         joint4_angle,
  input  logic                       cfg_wr_en,
  input  logic [15:0]                cfg_wr_data,
  output logic                       done,
  output logic signed [OUT_BITS-1:0] pos_x,
  output logic signed [OUT_BITS-1:0] pos_y,
  output logic signed [OUT_BITS-1:0] pos_z
);

  typedef struct packed {
    logic         valid;
    vec_t         col0;
    vec_t         col1;
    vec_t         col2;
    trig_t [3:1]  tr;
    acc_t         acc;
  } pipe_t;

  // link length register
  logic [15:0] link_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_length <= 16'(1 << FRAC_BITS);
    end else if (cfg_wr_en) begin
      link_length <= cfg_wr_data;
    end
  end

  // fully pipelined, never stalls
  assign busy = 1'b0;

  // quadrant split: round phase to nearest quarter turn, residual goes to cordic
  logic [3:0][15:0] ang;
  cord_t [3:0]      cst [0:CORDIC_STEPS];
  logic             cvld [0:CORDIC_STEPS];

  assign ang[0] = joint1_angle;
  assign ang[1] = joint2_angle;
  assign ang[2] = joint3_angle;
  assign ang[3] = joint4_angle;
  assign cvld[0] = start & ~busy;

  always_comb begin
    logic [31:0] phase;
    logic [31:0] d;
    logic [1:0]  q;
    for (int l = 0; l < 4; l++) begin
      phase = {ang[l][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
      q = 2'((phase + 32'h2000_0000) >> 30);
      d = phase - {q, 30'b0};
      cst[0][l].x = GAIN_INV;
      cst[0][l].y = '0;
      cst[0][l].z = ent_t'(signed'(d));
      cst[0][l].q = q;
    end
  end

  // cordic chain, one cell per iteration
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    afk_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (5'(i)),
      .in_valid  (cvld[i]),
      .in_lane   (cst[i]),
      .out_valid (cvld[i+1]),
      .out_lane  (cst[i+1])
    );
  end

  // clamp and quadrant fold into cos/sin per joint
  trig_t [3:0] trg;

  function automatic ent_t clamp1(input ent_t v);
    if (v > ONE_Q30) begin
      return ONE_Q30;
    end else if (v < -ONE_Q30) begin
      return -ONE_Q30;
    end
    return v;
  endfunction

  always_comb begin
    ent_t cx;
    ent_t cy;
    for (int l = 0; l < 4; l++) begin
      cx = clamp1(cst[CORDIC_STEPS][l].x);
      cy = clamp1(cst[CORDIC_STEPS][l].y);
      case (cst[CORDIC_STEPS][l].q)
        QUAD_0: begin trg[l].c = cx;  trg[l].s = cy;  end
        QUAD_1: begin trg[l].c = -cy; trg[l].s = cx;  end
        QUAD_2: begin trg[l].c = -cx; trg[l].s = -cy; end
        QUAD_3: begin trg[l].c = cy;  trg[l].s = -cx; end
        default: begin trg[l].c = cx; trg[l].s = cy;  end
      endcase
    end
  end

  // base joint about z gives the starting chain directly
  pipe_t p0;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0.valid <= 1'b0;
    end else begin
      p0.valid <= cvld[CORDIC_STEPS];
    end
    p0.col0  <= '{x: trg[0].c, y: trg[0].s, z: '0};
    p0.col1  <= '{x: -trg[0].s, y: trg[0].c, z: '0};
    p0.col2  <= '{x: '0, y: '0, z: ONE_Q30};
    p0.tr    <= trg[3:1];
    p0.acc.x <= 36'(trg[0].c);
    p0.acc.y <= 36'(trg[0].s);
    p0.acc.z <= '0;
  end

  // joint two about y: rotates columns 0 and 2
  pipe_t d2a, d2b, p1;
  vec_t  r2u, r2v;

  afk_rot_cell u_rot2 (
    .clk   (clk),
    .c     (p0.tr[1].c),
    .s     (p0.tr[1].s),
    .u     (p0.col0),
    .v     (p0.col2),
    .u_out (r2u),
    .v_out (r2v)
  );

  // joint three about x: columns 1 and 2, sine sign flipped
  pipe_t d3a, d3b, p2;
  vec_t  r3u, r3v;

  afk_rot_cell u_rot3 (
    .clk   (clk),
    .c     (p1.tr[2].c),
    .s     (-p1.tr[2].s),
    .u     (p1.col1),
    .v     (p1.col2),
    .u_out (r3u),
    .v_out (r3v)
  );

  // joint four about y: columns 0 and 2
  pipe_t d4a, d4b, p3;
  vec_t  r4u, r4v;

  afk_rot_cell u_rot4 (
    .clk   (clk),
    .c     (p2.tr[3].c),
    .s     (p2.tr[3].s),
    .u     (p2.col0),
    .v     (p2.col2),
    .u_out (r4u),
    .v_out (r4v)
  );

  // side pipeline keeps the untouched part of each beat aligned with the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      d2a.valid <= 1'b0;
      d2b.valid <= 1'b0;
      d3a.valid <= 1'b0;
      d3b.valid <= 1'b0;
      d4a.valid <= 1'b0;
      d4b.valid <= 1'b0;
    end else begin
      d2a.valid <= p0.valid;
      d2b.valid <= d2a.valid;
      d3a.valid <= p1.valid;
      d3b.valid <= d3a.valid;
      d4a.valid <= p2.valid;
      d4b.valid <= d4a.valid;
    end
    {d2a.col0, d2a.col1, d2a.col2, d2a.tr, d2a.acc} <= {p0.col0, p0.col1, p0.col2, p0.tr, p0.acc};
    {d2b.col0, d2b.col1, d2b.col2, d2b.tr, d2b.acc} <=
      {d2a.col0, d2a.col1, d2a.col2, d2a.tr, d2a.acc};
    {d3a.col0, d3a.col1, d3a.col2, d3a.tr, d3a.acc} <= {p1.col0, p1.col1, p1.col2, p1.tr, p1.acc};
    {d3b.col0, d3b.col1, d3b.col2, d3b.tr, d3b.acc} <=
      {d3a.col0, d3a.col1, d3a.col2, d3a.tr, d3a.acc};
    {d4a.col0, d4a.col1, d4a.col2, d4a.tr, d4a.acc} <= {p2.col0, p2.col1, p2.col2, p2.tr, p2.acc};
    {d4b.col0, d4b.col1, d4b.col2, d4b.tr, d4b.acc} <=
      {d4a.col0, d4a.col1, d4a.col2, d4a.tr, d4a.acc};
  end

  // column 0 after joint three equals column 0 after joint two, so it counts twice
  always_comb begin
    p1       = d2b;
    p1.col0  = r2u;
    p1.col2  = r2v;
    p1.acc.x = d2b.acc.x + (36'(r2u.x) <<< 1);
    p1.acc.y = d2b.acc.y + (36'(r2u.y) <<< 1);
    p1.acc.z = d2b.acc.z + (36'(r2u.z) <<< 1);

    p2       = d3b;
    p2.col1  = r3u;
    p2.col2  = r3v;

    p3       = d4b;
    p3.col0  = r4u;
    p3.col2  = r4v;
    p3.acc.x = d4b.acc.x + 36'(r4u.x);
    p3.acc.y = d4b.acc.y + 36'(r4u.y);
    p3.acc.z = d4b.acc.z + 36'(r4u.z);
  end

  // link length scaling
  logic               mvalid;
  logic signed [52:0] mx, my, mz;
  logic signed [16:0] len_s;

  assign len_s = signed'({1'b0, link_length});

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid <= 1'b0;
    end else begin
      mvalid <= p3.valid;
    end
  end

  always_ff @(posedge clk) begin
    mx <= len_s * p3.acc.x;
    my <= len_s * p3.acc.y;
    mz <= len_s * p3.acc.z;
  end

  // round to q7.12 and saturate
  function automatic logic signed [OUT_BITS-1:0] scale_sat(input logic signed [52:0] p);
    logic signed [53:0] t;
    logic signed [23:0] r;
    t = 54'(p) + (54'sd1 <<< 29);
    r = 24'(t >>> 30);
    if (r > 24'sd524287) begin
      return 20'sd524287;
    end else if (r < -24'sd524288) begin
      return -20'sd524288;
    end
    return r[OUT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mvalid;
    end
  end

  always_ff @(posedge clk) begin
    pos_x <= scale_sat(mx);
    pos_y <= scale_sat(my);
    pos_z <= scale_sat(mz);
  end

endmodule
`default_nettype wire

[rtl/afk_checker.sv]
// port-level checks of the kinematics unit, bound to the top level
`default_nettype none
`include "arm_forward_kinematics_4dof_unit_macros.svh"
module afk_checker import afk_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `AFK_ASSERT_IMPL(a_never_busy, 1'b1, !busy, "busy raised")
  `AFK_ASSERT_NEXT(a_reset_quiet, rst, !done, "result beat right after reset")
  `AFK_ASSERT_IMPL(a_beat_out, start && !busy, ##LATENCY done, "accepted beat gave no result")
  `AFK_ASSERT_IMPL(a_no_extra, done, $past(start, LATENCY), "result beat with no input beat")

endmodule

bind arm_forward_kinematics_4dof_unit afk_checker u_afk_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire

[tb/sv/tb_arm_forward_kinematics_4dof_unit.sv]
// self-checking testbench of the four-joint arm forward kinematics unit
`default_nettype none
module tb_arm_forward_kinematics_4dof_unit;
  import afk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 1700;
  localparam int CYC_LIMIT = 400000;

  // expected end-effector position of one beat
  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } pos_t;

  typedef enum int {AX_X = 0, AX_Y = 1, AX_Z = 2} axis_e;

  typedef longint mat_t [3][3];

  // scoreboard: predicts each accepted beat and checks results in order
  class pos_scoreboard;
    pos_t   pending[$];
    longint link_len;
    int     errors;
    longint atan_lut[30];

    function new();
      atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};
      link_len = 4096;
      errors = 0;
    endfunction

    // >>> on longint is arithmetic, i.e. floor
    function longint rnd30(longint v);
      return (v + (longint'(1) << 29)) >>> 30;
    endfunction

    function longint clamp1(longint v);
      if (v > 1073741824) return 1073741824;
      if (v < -1073741824) return -1073741824;
      return v;
    endfunction

    function void trig(logic [15:0] ang, output longint c, output longint s);
      logic [31:0] phase, d;
      logic [1:0]  q;
      longint x, y, z, dx, dy;
      phase = {ang, 16'h0};
      q = 2'((phase + 32'h2000_0000) >> 30);
      d = phase - {q, 30'h0};
      z = longint'($signed(d));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_lut[i];
        end else begin
          x += dx; y -= dy; z += atan_lut[i];
        end
      end
      x = clamp1(x);
      y = clamp1(y);
      case (q)
        QUAD_0: begin c = x; s = y; end
        QUAD_1: begin c = -y; s = x; end
        QUAD_2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function mat_t rot(axis_e ax, logic [15:0] ang);
      mat_t r;
      longint c, s;
      trig(ang, c, s);
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) r[a][b] = (a == b) ? 1073741824 : 0;
      case (ax)
        AX_X: begin r[1][1] = c; r[1][2] = -s; r[2][1] = s; r[2][2] = c; end
        AX_Y: begin r[0][0] = c; r[0][2] = s; r[2][0] = -s; r[2][2] = c; end
        default: begin r[0][0] = c; r[0][1] = -s; r[1][0] = s; r[1][1] = c; end
      endcase
      return r;
    endfunction

    function logic signed [19:0] sat_out(longint sum);
      longint v;
      v = rnd30(link_len * sum);
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return 20'(v);
    endfunction

    function void note_beat(logic [15:0] j1, logic [15:0] j2, logic [15:0] j3,
                            logic [15:0] j4);
      axis_e  axes[4];
      logic [15:0] angs[4];
      mat_t   chain, r, t;
      longint sum[3];
      longint acc;
      pos_t   p;
      axes = '{AX_Z, AX_Y, AX_X, AX_Y};
      angs = '{j1, j2, j3, j4};
      chain = rot(axes[0], angs[0]);
      for (int a = 0; a < 3; a++) sum[a] = chain[a][0];
      for (int j = 1; j < 4; j++) begin
        r = rot(axes[j], angs[j]);
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += chain[a][k] * r[k][b];
            t[a][b] = rnd30(acc);
          end
        chain = t;
        for (int a = 0; a < 3; a++) sum[a] += chain[a][0];
      end
      p.x = sat_out(sum[0]);
      p.y = sat_out(sum[1]);
      p.z = sat_out(sum[2]);
      pending.push_back(p);
    endfunction

    function void check_result(logic signed [19:0] x, logic signed [19:0] y,
                               logic signed [19:0] z);
      pos_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %0d %0d %0d", x, y, z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin $error("pos_x exp %0d got %0d", e.x, x); errors++; end
      if (y !== e.y) begin $error("pos_y exp %0d got %0d", e.y, y); errors++; end
      if (z !== e.z) begin $error("pos_z exp %0d got %0d", e.z, z); errors++; end
    endfunction
  endclass

  logic clk, rst, start, cfg_wr_en;
  logic busy, done;
  logic signed [15:0] joint1_angle, joint2_angle, joint3_angle, joint4_angle;
  logic [15:0] cfg_wr_data;
  logic signed [OUT_BITS-1:0] pos_x, pos_y, pos_z;

  pos_scoreboard sb;
  int cycles;

  arm_forward_kinematics_4dof_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .joint1_angle(joint1_angle), .joint2_angle(joint2_angle),
    .joint3_angle(joint3_angle), .joint4_angle(joint4_angle),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // result monitor: done cannot be held off, so every done beat is checked
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(pos_x, pos_y, pos_z);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("arm_forward_kinematics_4dof_unit: mismatch");
      $finish;
    end
  end

  // angle that favors quadrant edges, extremes and zero now and then
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 3) << 14) + 16'($signed($urandom_range(0, 6)) - 3);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 7) << 13);
      default: return 16'($urandom);
    endcase
  endfunction

  // one start beat; hold start high across back-to-back beats
  task automatic send_beat(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3,
                           logic [15:0] a4, bit keep);
    start <= 1'b1;
    joint1_angle <= a1;
    joint2_angle <= a2;
    joint3_angle <= a3;
    joint4_angle <= a4;
    do @(posedge clk); while (busy);
    sb.note_beat(a1, a2, a3, a4);
    if (!keep) start <= 1'b0;
  endtask

  // wait until every expected beat is back, plus pipeline slack
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_length(logic [15:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.link_len = v;
  endtask

  task automatic random_phase(int n);
    int left, burst, gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      // random gap, sometimes none; with no gap start stays high into the next burst
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 50) : 0;
      for (int i = 0; i < burst; i++)
        send_beat(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                  (i != burst - 1) || (gap == 0 && left > burst));
      left -= burst;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [15:0] lens[6];
    sb = new();
    cycles = 0;
    rst <= 1'b1;
    start <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    joint1_angle <= '0;
    joint2_angle <= '0;
    joint3_angle <= '0;
    joint4_angle <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset length, extremes, quarter turns, half turn
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1);
    send_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1);
    send_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
    send_beat(16'h4000, 16'hc000, 16'h4000, 16'hc000, 1);
    send_beat(16'h2000, 16'h1fff, 16'he000, 16'hdfff, 1);
    send_beat(16'hffff, 16'h0001, 16'h5555, 16'haaaa, 0);
    // full length: the largest link_length, still below the saturation limits
    write_length(16'hffff);
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1);
    send_beat(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1);
    send_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 1);
    send_beat(16'h0000, 16'hc000, 16'h0000, 16'hc000, 1);
    send_beat(16'h0000, 16'h4000, 16'h0000, 16'h4000, 0);
    write_length(16'h0000);
    send_beat(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 0);

    lens = '{16'h0000, 16'hffff, 16'h1000, 16'h0001, 16'h8000, 16'h0000};
    for (int p = 0; p < 6; p++) begin
      if (p == 5) lens[p] = 16'($urandom);
      write_length(lens[p]);
      random_phase(N_RANDOM / 6);
    end
    // hold off until everything is back, then a last burst
    drain();
    random_phase(20);
    drain();

    if (sb.errors == 0) begin
      $display("arm_forward_kinematics_4dof_unit: match");
    end else begin
      $display("arm_forward_kinematics_4dof_unit: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
